@@ hdl/pvenc_pkg.sv @@
package pvenc_pkg;

   localparam int VALUE_W    = 64;
   localparam int FRAME_W    = 72;
   localparam int COUNT_W    = 4;
   localparam int SHORT_BITS = 34;
   localparam int SHORT_W    = SHORT_BITS + 2;

   localparam logic [1:0] OP_META     = 2'd0;
   localparam logic [1:0] OP_UNSIGNED = 2'd1;
   localparam logic [1:0] OP_SIGNED   = 2'd2;

   localparam logic [4:0] HDR_ONES = 5'b11111;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SIZE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic shift;
   } shift_ctrl_type;

endpackage

@@ hdl/pvenc_frame.sv @@
module pvenc_frame
   import pvenc_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   input  logic               meta,
   output logic [FRAME_W-1:0] frame,
   output logic [COUNT_W-1:0] count
);

   logic [7:0]           byte_nz;
   logic                 any_nz;
   logic [2:0]           top_idx;
   logic [7:0]           top_byte;
   logic [3:0]           top_len;
   logic [6:0]           value_len;
   logic [6:0]           word_len;
   logic [2:0]           pad;
   logic                 is_short;
   logic [SHORT_W-1:0]   word0;
   logic [FRAME_W-1:0]   pad_ones;
   logic [7:0]           header;

   always_comb begin
      for (int j = 0; j < 8; j++) begin
         byte_nz[j] = |value[8*j +: 8];
      end
   end

   // Highest nonzero byte, then the bit length inside that byte.
   always_comb begin
      top_idx = 3'd0;
      for (int j = 0; j < 8; j++) begin
         if (byte_nz[j]) begin
            top_idx = 3'(j);
         end
      end
   end

   assign any_nz   = |byte_nz;
   assign top_byte = value[{top_idx, 3'b000} +: 8];

   always_comb begin
      top_len = 4'd0;
      for (int i = 0; i < 8; i++) begin
         if (top_byte[i]) begin
            top_len = 4'(i + 1);
         end
      end
   end

   assign value_len = any_nz ? ({1'b0, top_idx, 3'b000} + {3'b000, top_len}) : 7'd0;

   always_comb begin
      if (any_nz) begin
         word_len = value_len + 7'd2;
      end else if (meta) begin
         word_len = 7'd2;
      end else begin
         word_len = 7'd0;
      end
   end

   // Each added prefix one costs a bit and buys a byte of eight, so the
   // number of ones is the bit excess over one byte, rounded up in sevens.
   always_comb begin
      if (word_len <= 7'd8) begin
         pad = 3'd0;
      end else if (word_len <= 7'd15) begin
         pad = 3'd1;
      end else if (word_len <= 7'd22) begin
         pad = 3'd2;
      end else if (word_len <= 7'd29) begin
         pad = 3'd3;
      end else begin
         pad = 3'd4;
      end
   end

   assign is_short = ~|value[VALUE_W-1:SHORT_BITS];
   assign word0    = {value[SHORT_BITS-1:0], meta, 1'b0};
   assign pad_ones = (FRAME_W'(1) << pad) - FRAME_W'(1);
   assign header   = {meta, top_idx[1:0], HDR_ONES};

   always_comb begin
      if (is_short) begin
         frame = (FRAME_W'(word0) << pad) | pad_ones;
         count = COUNT_W'(pad) + COUNT_W'(1);
      end else begin
         frame = {value, header};
         count = COUNT_W'(top_idx) + COUNT_W'(2);
      end
   end

endmodule

@@ hdl/pvenc_shift.sv @@
module pvenc_shift
   import pvenc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  shift_ctrl_type     ctrl,
   input  logic [FRAME_W-1:0] frame,
   input  logic [COUNT_W-1:0] count,
   output logic [7:0]         out_byte,
   output logic               last_byte
);

   logic [FRAME_W-1:0] frame_ff, frame_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   always_comb begin
      frame_in = frame_ff;
      count_in = count_ff;
      if (ctrl.load) begin
         frame_in = frame;
         count_in = count;
      end else if (ctrl.shift) begin
         frame_in = frame_ff >> 8;
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign out_byte  = frame_ff[7:0];
   assign last_byte = (count_ff == COUNT_W'(1));

endmodule

@@ hdl/prefix_varint_encoder.sv @@
// Prefix varint encoder: one request gives 1 to 9 bytes, one per cycle.
// The request is registered, then the size state loads the output shift
// register, whose shifts set the byte rate in the emit state. Busy is high
// in both states, so no new request is taken before the last byte has gone.
// Synchronous reset clears the controller and the byte counter; no byte
// strobe follows reset until a new request. The receiver cannot stall.
module prefix_varint_encoder
   import pvenc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_operation,
   input  logic [VALUE_W-1:0] req_data_value,
   input  logic               req_meta_bit,
   output logic               rsp_valid,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_last_byte
);

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               meta_ff, meta_in;
   logic               accept;
   logic [FRAME_W-1:0] frame;
   logic [COUNT_W-1:0] count;
   shift_ctrl_type     ctrl;

   assign accept = start && (state_ff == ST_IDLE);

   // Zigzag of a signed value folds to the low 63 bits xored with the sign,
   // and the sign itself becomes the meta bit.
   always_comb begin
      unique case (req_operation)
         OP_UNSIGNED: begin
            value_in = {1'b0, req_data_value[VALUE_W-1:1]};
            meta_in  = req_data_value[0];
         end
         OP_SIGNED: begin
            value_in = {1'b0, req_data_value[VALUE_W-2:0] ^
                        {(VALUE_W-1){req_data_value[VALUE_W-1]}}};
            meta_in  = req_data_value[VALUE_W-1];
         end
         default: begin
            value_in = req_data_value;
            meta_in  = req_meta_bit;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff <= value_in;
         meta_ff  <= meta_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_SIZE;
            end
         end
         ST_SIZE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_last_byte) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy       = 1'b1;
      rsp_valid  = 1'b0;
      ctrl.load  = 1'b0;
      ctrl.shift = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_SIZE: begin
            ctrl.load = 1'b1;
         end
         ST_EMIT: begin
            rsp_valid  = 1'b1;
            ctrl.shift = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   pvenc_frame u_frame (
      .value (value_ff),
      .meta  (meta_ff),
      .frame (frame),
      .count (count)
   );

   pvenc_shift u_shift (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .frame     (frame),
      .count     (count),
      .out_byte  (rsp_out_byte),
      .last_byte (rsp_last_byte)
   );

endmodule
